// ===== rtl/core/rsa_me_pkg.sv =====
`default_nettype none

package rsa_me_pkg;

    // Default word width of the datapath
    localparam int unsigned DEF_WORD_WIDTH = 64;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_MODULUS          = 2'd0;
    localparam t_cfg_idx CFG_PUBLIC_EXPONENT  = 2'd1;
    localparam t_cfg_idx CFG_PRIVATE_EXPONENT = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/rsa_me_mulmod.sv =====
`default_nettype none

// Bit-serial modular multiplier: one bit of b per cycle, MSB first.
// i_m must stay stable while busy; a and b are captured on start.
module rsa_me_mulmod #(
    parameter int unsigned WORD_WIDTH = rsa_me_pkg::DEF_WORD_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [WORD_WIDTH-1:0] i_a,
    input  wire logic [WORD_WIDTH-1:0] i_b,
    input  wire logic [WORD_WIDTH-1:0] i_m,
    output logic                       o_done,
    output logic [WORD_WIDTH-1:0]      o_result
);
    import rsa_me_pkg::*;

    localparam int unsigned W  = WORD_WIDTH;
    localparam int unsigned CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_a;
    logic [W-1:0]  r_b;
    logic [W-1:0]  r_r;

    logic [W+1:0]  w_sum;
    logic [W+1:0]  w_sub1;
    logic [W+1:0]  w_sub2;
    logic [W-1:0]  n_r;

    // Double the partial product, add a when the bit is set, then take off
    // m or 2m; the sum stays below 3m so one of the three is in range.
    always_comb begin
        w_sum  = {1'b0, r_r, 1'b0} + {2'b00, (r_b[W-1] ? r_a : {W{1'b0}})};
        w_sub1 = w_sum - {2'b00, i_m};
        w_sub2 = w_sum - {1'b0, i_m, 1'b0};
        if (!w_sub2[W+1]) begin
            n_r = w_sub2[W-1:0];
        end else if (!w_sub1[W+1]) begin
            n_r = w_sub1[W-1:0];
        end else begin
            n_r = w_sum[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
            r_b <= i_b;
            r_r <= '0;
        end else if (r_busy) begin
            r_b <= {r_b[W-2:0], 1'b0};
            r_r <= n_r;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_r;

endmodule

`default_nettype wire

// ===== rtl/core/rsa_modular_exponentiation_core.sv =====
`default_nettype none

// Channel   Direction  Handshake            Payload
// request   in         i_valid / o_ready    i_operation, i_value
// result    out        o_valid / i_ready    o_result, o_too_large
// config    in         i_cfg_wr_en          i_cfg_index, i_cfg_data
//
// One request at a time. Decrypt first reduces the value modulo n. Each
// exponent bit up to the top set bit then takes one pass of the bit-serial
// multipliers, which retire one multiplier bit per cycle. Rejected messages
// and a modulus of 0 or 1 go straight to the write state.
// Reset is synchronous, active low; it restores the default key registers.
// A finished result waits in the output register; the next request is taken
// meanwhile, and its result holds in the core until the register frees.
module rsa_modular_exponentiation_core #(
    parameter int unsigned WORD_WIDTH = rsa_me_pkg::DEF_WORD_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // request channel
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_operation,
    input  wire logic [WORD_WIDTH-1:0] i_value,
    // result channel
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [WORD_WIDTH-1:0]      o_result,
    output logic                       o_too_large,
    // configuration
    input  wire logic                  i_cfg_wr_en,
    input  wire rsa_me_pkg::t_cfg_idx  i_cfg_index,
    input  wire logic [WORD_WIDTH-1:0] i_cfg_data
);
    import rsa_me_pkg::*;

    localparam int unsigned W = WORD_WIDTH;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_REDUCE = 5'b00010,
        S_STEP   = 5'b00100,
        S_MUL    = 5'b01000,
        S_WRITE  = 5'b10000
    } t_state;

    t_state       r_state;
    t_state       n_state;

    // key registers
    logic [W-1:0] r_mod;
    logic [W-1:0] r_pub;
    logic [W-1:0] r_priv;

    // exponentiation datapath
    logic [W-1:0] r_ex;
    logic [W-1:0] r_acc;
    logic [W-1:0] r_sq;
    logic         r_flag;

    // output register
    logic         r_out_valid;
    logic [W-1:0] r_out_result;
    logic         r_out_flag;

    logic         w_accept;
    logic         w_too_large;
    logic         w_mod_le1;
    logic         w_start_a;
    logic         w_start_b;
    logic [W-1:0] w_a_in;
    logic [W-1:0] w_b_in;
    logic         w_done_a;
    logic         w_done_b;
    logic [W-1:0] w_res_a;
    logic [W-1:0] w_res_b;
    logic         w_out_free;

    assign w_accept    = i_valid && o_ready;
    assign w_too_large = !i_operation && (i_value >= r_mod);
    assign w_mod_le1   = (r_mod[W-1:1] == '0);
    assign w_out_free  = !r_out_valid || i_ready;

    // Unit A reduces the decrypt base (1 * value) on accept, then forms
    // acc * sq per exponent bit; unit B squares alongside it.
    assign w_start_a = (w_accept && i_operation && !w_mod_le1) || (r_state == S_STEP && r_ex != '0);
    assign w_start_b = (r_state == S_STEP) && (r_ex != '0);
    assign w_a_in    = (r_state == S_IDLE) ? W'(1) : r_acc;
    assign w_b_in    = (r_state == S_IDLE) ? i_value : r_sq;

    rsa_me_mulmod #(
        .WORD_WIDTH (W)
    ) u_mul_acc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start_a),
        .i_a      (w_a_in),
        .i_b      (w_b_in),
        .i_m      (r_mod),
        .o_done   (w_done_a),
        .o_result (w_res_a)
    );

    rsa_me_mulmod #(
        .WORD_WIDTH (W)
    ) u_mul_sq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start_b),
        .i_a      (r_sq),
        .i_b      (r_sq),
        .i_m      (r_mod),
        .o_done   (w_done_b),
        .o_result (w_res_b)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_too_large || w_mod_le1) begin
                        n_state = S_WRITE;
                    end else if (i_operation) begin
                        n_state = S_REDUCE;
                    end else begin
                        n_state = S_STEP;
                    end
                end
            end
            S_REDUCE: begin
                if (w_done_a) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                n_state = (r_ex == '0) ? S_WRITE : S_MUL;
            end
            S_MUL: begin
                if (w_done_a) begin
                    n_state = S_STEP;
                end
            end
            S_WRITE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mod       <= W'(1);
            r_pub       <= W'(32'd65537);
            r_priv      <= W'(1);
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_MODULUS:          r_mod  <= i_cfg_data;
                    CFG_PUBLIC_EXPONENT:  r_pub  <= i_cfg_data;
                    CFG_PRIVATE_EXPONENT: r_priv <= i_cfg_data;
                    default: begin
                        // drop writes to unmapped indexes
                    end
                endcase
            end
            if (r_state == S_WRITE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    r_ex   <= i_operation ? r_priv : r_pub;
                    r_flag <= w_too_large;
                    r_acc  <= (w_too_large || w_mod_le1) ? '0 : W'(1);
                    r_sq   <= i_value;
                end
            end
            S_REDUCE: begin
                if (w_done_a) begin
                    r_sq <= w_res_a;
                end
            end
            S_MUL: begin
                if (w_done_a) begin
                    // take the product only where the exponent bit is set
                    if (r_ex[0]) begin
                        r_acc <= w_res_a;
                    end
                    r_sq <= w_res_b;
                    r_ex <= {1'b0, r_ex[W-1:1]};
                end
            end
            S_WRITE: begin
                if (w_out_free) begin
                    r_out_result <= r_acc;
                    r_out_flag   <= r_flag;
                end
            end
            default: begin
                // hold
            end
        endcase
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_result    = r_out_result;
    assign o_too_large = r_out_flag;

    // Both multipliers run in lock step through an exponent bit.
    a_mul_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (w_done_a == w_done_b))
        else $error("multiplier units out of step");

    // A rejected message always reports a zero result.
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_too_large) |-> (o_result == '0))
        else $error("too_large result not zero");

    // Results are reduced below a modulus greater than one.
    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (r_mod[W-1:1] != '0)) |-> (o_result < r_mod))
        else $error("result not below modulus");

    // A new result appears only out of the write state.
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_WRITE))
        else $error("output loaded outside write state");

    // Accepting a request closes the input side.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_ready)
        else $error("request taken while busy");

endmodule

`default_nettype wire
